// ===== rtl/core/dcbh_pkg.sv =====
// Shared types and constants for the decimating DC-blocking high-pass unit.
// No dependencies; imported by every module of the block.
package dcbh_pkg;

  localparam int SAMPLE_W = 16;
  localparam int FACTOR_W = 5;
  localparam int GAIN_W   = 24;
  localparam int COEF_W   = 17;
  localparam int ACC_W    = 40;
  localparam int FRAC_W   = 8;
  localparam int COEF_FRAC_W = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  localparam logic [FACTOR_W-1:0] FACTOR_RESET = 5'd1;
  localparam logic [GAIN_W-1:0]   GAIN_RESET   = 24'd65536;
  localparam logic [COEF_W-1:0]   COEF_RESET   = 17'd64880;
  localparam logic [COEF_W-1:0]   COEF_ONE     = 17'd65536;

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
  localparam logic signed [SAMPLE_W-1:0] OUT_MAX = 16'sd32767;
  localparam logic signed [SAMPLE_W-1:0] OUT_MIN = -16'sd32767;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DECIMATION = 2'd0,
    REG_GAIN       = 2'd1,
    REG_POLE       = 2'd2
  } cfg_reg_t;

  typedef enum logic {
    KIND_SAMPLE = 1'b0,
    KIND_CLEAR  = 1'b1
  } kind_t;

  typedef struct packed {
    logic                    clear;
    logic signed [ACC_W-1:0] x;
  } stage_t;

endpackage

// ===== rtl/core/dcbh_hpf.sv =====
// First-order DC-blocking feedback section with output truncation and clipping.
// Depends on dcbh_pkg for widths, limits and the stage word type.
module dcbh_hpf import dcbh_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  stage_t                     word,
  input  logic [COEF_W-1:0]          pole_coefficient,
  output logic signed [SAMPLE_W-1:0] q
);

  localparam int MUL_W = ACC_W + COEF_W + 1;
  localparam int FB_W  = MUL_W - COEF_FRAC_W;
  localparam int SUM_W = FB_W + 1;
  localparam int RND_W = ACC_W + 1;
  localparam int QW    = RND_W - FRAC_W;

  logic signed [ACC_W-1:0] prev_x;
  logic signed [ACC_W-1:0] prev_y;
  logic signed [ACC_W-1:0] y_next;
  logic [COEF_W-1:0]       c_eff;
  logic signed [MUL_W-1:0] fb_prod;
  logic signed [FB_W-1:0]  fb;
  logic signed [SUM_W-1:0] y_sum;
  logic signed [RND_W-1:0] y_adj;
  logic signed [QW-1:0]    y_int;

  assign c_eff   = (pole_coefficient > COEF_ONE) ? COEF_ONE : pole_coefficient;
  assign fb_prod = MUL_W'(prev_y) * MUL_W'($signed({1'b0, c_eff}));
  assign fb      = fb_prod[MUL_W-1:COEF_FRAC_W];
  assign y_sum   = SUM_W'(word.x) - SUM_W'(prev_x) + SUM_W'(fb);

  always_comb begin
    if (y_sum > SUM_W'(ACC_MAX)) begin
      y_next = ACC_MAX;
    end else if (y_sum < SUM_W'(ACC_MIN)) begin
      y_next = ACC_MIN;
    end else begin
      y_next = y_sum[ACC_W-1:0];
    end
  end

  // Adding 255 before the arithmetic shift truncates negative values toward zero.
  assign y_adj = RND_W'(y_next) + (y_next[ACC_W-1] ? RND_W'(255) : RND_W'(0));
  assign y_int = y_adj[RND_W-1:FRAC_W];

  always_comb begin
    if (y_int > QW'(OUT_MAX)) begin
      q = OUT_MAX;
    end else if (y_int < QW'(OUT_MIN)) begin
      q = OUT_MIN;
    end else begin
      q = y_int[SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_x <= '0;
      prev_y <= '0;
    end else if (en) begin
      if (word.clear) begin
        prev_x <= '0;
        prev_y <= '0;
      end else begin
        prev_x <= word.x;
        prev_y <= y_next;
      end
    end
  end

endmodule

// ===== rtl/core/decimating_dc_block_highpass_unit.sv =====
// Top level of the decimating DC-blocking high-pass unit: boxcar decimator, gain stage
// and result register. Depends on dcbh_pkg and instantiates dcbh_hpf.
//
// Words arrive on the input channel (in_valid/in_ready) as a kind and a 16-bit sample.
// A sample word adds to the running group sum; the word that completes a group of
// decimation_factor samples yields one filtered_sample on the output channel
// (out_valid/out_ready). A clear word yields nothing; it zeroes the group and the
// filter memory in order with the surrounding words.
// The accepting edge loads the scaled group sum into the first register; the result
// register is loaded from it once the output is free or taken, and out_valid rises with
// it. One word is accepted every cycle while the output does not stall;
// the recursion through the previous output is a single combinational multiply-add,
// which allows that rate.
// Configuration is written through cfg_valid/cfg_ready with cfg_index and cfg_data;
// cfg_ready is always high. Write only while the unit is idle.
// Reset restores the register defaults and zeroes all filter state at once.
// When the receiver stalls, the result register holds its word, the scaled stage fills,
// and in_ready falls until the result is taken.
module decimating_dc_block_highpass_unit import dcbh_pkg::*; #(
  parameter int MAX_DECIMATION = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        kind,
  input  logic signed [SAMPLE_W-1:0]  audio_sample,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [SAMPLE_W-1:0]  filtered_sample,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [CFG_DATA_W-1:0]       cfg_data
);

  localparam int SUM_W  = SAMPLE_W + $clog2(MAX_DECIMATION);
  localparam int CNT_W  = $clog2(MAX_DECIMATION + 1);
  localparam int FAC_W  = (CNT_W > FACTOR_W) ? CNT_W : FACTOR_W;
  localparam int PROD_W = SUM_W + GAIN_W + 1;
  localparam int XW     = PROD_W - FRAC_W;
  localparam logic [FAC_W-1:0] MAX_FAC = FAC_W'(MAX_DECIMATION);

  logic [FACTOR_W-1:0] decimation_factor;
  logic [GAIN_W-1:0]   gain_scale;
  logic [COEF_W-1:0]   pole_coefficient;

  logic signed [SUM_W-1:0] group_sum;
  logic [CNT_W-1:0]        group_count;
  logic signed [SUM_W-1:0] group_sum_next;
  logic [FAC_W-1:0]        count_next;
  logic [FAC_W-1:0]        fac_ext;
  logic [FAC_W-1:0]        eff_factor;
  logic                    complete;
  logic signed [PROD_W-1:0] prod;
  logic signed [XW-1:0]    x_short;
  logic signed [ACC_W-1:0] x_full;

  logic   s1_valid;
  stage_t s1_word;
  logic   s1_go;
  logic   in_fire;
  logic   out_fire;
  logic   is_clear;
  logic signed [SAMPLE_W-1:0] q;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      decimation_factor <= FACTOR_RESET;
      gain_scale        <= GAIN_RESET;
      pole_coefficient  <= COEF_RESET;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_DECIMATION: decimation_factor <= cfg_data[FACTOR_W-1:0];
        REG_GAIN:       gain_scale        <= cfg_data[GAIN_W-1:0];
        REG_POLE:       pole_coefficient  <= cfg_data[COEF_W-1:0];
        default: ;
      endcase
    end
  end

  assign fac_ext    = FAC_W'(decimation_factor);
  assign eff_factor = (fac_ext == '0) ? FAC_W'(1) :
                      ((fac_ext > MAX_FAC) ? MAX_FAC : fac_ext);

  assign group_sum_next = group_sum + SUM_W'(audio_sample);
  assign count_next     = FAC_W'(group_count) + FAC_W'(1);
  assign complete       = (count_next >= eff_factor);

  assign prod    = PROD_W'(group_sum_next) * PROD_W'($signed({1'b0, gain_scale}));
  assign x_short = prod[PROD_W-1:FRAC_W];
  assign x_full  = {{(ACC_W-XW){x_short[XW-1]}}, x_short};

  assign is_clear = (kind_t'(kind) == KIND_CLEAR);
  assign s1_go    = s1_valid && (s1_word.clear || !out_valid || out_ready);
  assign in_ready = !s1_valid || s1_go;
  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      group_sum   <= '0;
      group_count <= '0;
    end else if (in_fire) begin
      if (is_clear || complete) begin
        group_sum   <= '0;
        group_count <= '0;
      end else begin
        group_sum   <= group_sum_next;
        group_count <= count_next[CNT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= is_clear || complete;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_word.clear <= is_clear;
      s1_word.x     <= x_full;
    end
  end

  dcbh_hpf u_hpf (
    .clk              (clk),
    .rst              (rst),
    .en               (s1_go),
    .word             (s1_word),
    .pole_coefficient (pole_coefficient),
    .q                (q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go && !s1_word.clear) begin
      out_valid <= 1'b1;
    end else if (out_fire) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && !s1_word.clear) begin
      filtered_sample <= q;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    FAC_W'(group_count) < MAX_FAC)
    else $error("group count reached the maximum decimation factor");

  a_clear_group: assert property (@(posedge clk) disable iff (rst)
    (in_fire && is_clear) |=> (group_sum == '0 && group_count == '0 && s1_valid))
    else $error("clear word did not restart the group");

  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_go) |-> !in_ready)
    else $error("input accepted while the scaled stage was blocked");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!out_valid && !s1_valid))
    else $error("pipeline not empty after reset");

endmodule

// ===== bench/decimating_dc_block_highpass_unit_tb.sv =====
// Self-checking testbench for decimating_dc_block_highpass_unit: directed and random words,
// with predicted results compared in order against the output channel.
// Depends on dcbh_pkg and the unit's RTL.
`timescale 1ns / 1ps

module decimating_dc_block_highpass_unit_tb;
  import dcbh_pkg::*;

  localparam int MAX_DEC = 16;
  localparam int IDLE_PCT = 36;
  localparam int SETTLE_CYCLES = 6;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam longint ACC_HI = (64'sd1 <<< 39) - 1;
  localparam longint ACC_LO = -(64'sd1 <<< 39);
  localparam longint CLIP = 32767;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic kind = KIND_SAMPLE;
  logic signed [SAMPLE_W-1:0] audio_sample = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [SAMPLE_W-1:0] filtered_sample;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  decimating_dc_block_highpass_unit #(.MAX_DECIMATION(MAX_DEC)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .kind(kind), .audio_sample(audio_sample),
    .out_valid(out_valid), .out_ready(out_ready), .filtered_sample(filtered_sample),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Predictor copy of the registers and the filter memory.
  logic [FACTOR_W-1:0] model_factor;
  logic [GAIN_W-1:0] model_gain;
  logic [COEF_W-1:0] model_pole;
  longint group_acc;
  int group_len;
  longint last_scaled;
  longint last_filtered;

  logic signed [SAMPLE_W-1:0] expected_out[$];
  logic signed [SAMPLE_W-1:0] want;
  bit steady = 1'b0;
  int errors = 0;
  int words_sent = 0;
  int results_checked = 0;
  int reg_writes = 0;

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  function automatic longint clamp40(longint v);
    if (v > ACC_HI) return ACC_HI;
    if (v < ACC_LO) return ACC_LO;
    return v;
  endfunction

  task automatic predict_word(logic k, logic signed [SAMPLE_W-1:0] s);
    longint x;
    longint fb;
    longint y;
    longint q;
    longint c;
    int f;
    if (k == KIND_CLEAR) begin
      group_acc = 0;
      group_len = 0;
      last_scaled = 0;
      last_filtered = 0;
      return;
    end
    group_acc += longint'(s);
    group_len++;
    f = int'(model_factor);
    if (f == 0) f = 1;
    if (f > MAX_DEC) f = MAX_DEC;
    if (group_len < f) return;
    x = clamp40((group_acc * longint'(model_gain)) >>> FRAC_W);
    c = (model_pole > COEF_ONE) ? longint'(COEF_ONE) : longint'(model_pole);
    fb = (last_filtered * c) >>> COEF_FRAC_W;
    y = clamp40(x - last_scaled + fb);
    last_scaled = x;
    last_filtered = y;
    group_acc = 0;
    group_len = 0;
    q = (y >= 0) ? (y >>> FRAC_W) : -((-y) >>> FRAC_W);
    if (q > CLIP) q = CLIP;
    if (q < -CLIP) q = -CLIP;
    expected_out.push_back(q[SAMPLE_W-1:0]);
  endtask

  task automatic note_error(string what, logic signed [SAMPLE_W-1:0] exp_v,
                            logic signed [SAMPLE_W-1:0] act_v);
    errors++;
    if (errors <= 10)
      $display("%0t: %s: expected %0d, got %0d", $time, what, exp_v, act_v);
  endtask

  // Called at a falling edge; returns at the falling edge after acceptance with valid high.
  task automatic send_word(logic k, logic signed [SAMPLE_W-1:0] s);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    kind <= k;
    audio_sample <= s;
    do @(posedge clk); while (!in_ready);
    predict_word(k, s);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_out.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_DECIMATION: model_factor = data[FACTOR_W-1:0];
      REG_GAIN:       model_gain = data[GAIN_W-1:0];
      REG_POLE:       model_pole = data[COEF_W-1:0];
      default: ;
    endcase
    reg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_all(int f, int g, int p);
    logic [CFG_DATA_W-1:0] junk;
    junk = CFG_DATA_W'($urandom);
    write_reg(REG_DECIMATION, {junk[CFG_DATA_W-1:FACTOR_W], f[FACTOR_W-1:0]});
    write_reg(REG_GAIN, g[GAIN_W-1:0]);
    write_reg(REG_POLE, {junk[CFG_DATA_W-1:COEF_W], p[COEF_W-1:0]});
  endtask

  function automatic logic signed [SAMPLE_W-1:0] pick_sample(int offset);
    int v;
    case ($urandom_range(9))
      0: v = 32767;
      1: v = -32768;
      2, 3, 4: v = offset + $urandom_range(200) - 100;
      default: v = $signed(16'($urandom));
    endcase
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[SAMPLE_W-1:0];
  endfunction

  always @(negedge clk)
    out_ready <= steady ? 1'b1 : ($urandom_range(99) >= IDLE_PCT);

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_out.size() == 0) begin
        note_error("unexpected result word", '0, filtered_sample);
      end else begin
        want = expected_out.pop_front();
        if (filtered_sample !== want) note_error("filtered_sample", want, filtered_sample);
        results_checked++;
      end
    end
  end

  task automatic test_reset_defaults();
    send_word(KIND_SAMPLE, 16'sd32767);
    send_word(KIND_SAMPLE, -16'sd32768);
    send_word(KIND_SAMPLE, -16'sd32768);
    send_word(KIND_SAMPLE, 16'sd0);
    send_word(KIND_SAMPLE, -16'sd1);
    wait_idle();
  endtask

  task automatic test_clear_word();
    send_word(KIND_SAMPLE, 16'sd1000);
    send_word(KIND_CLEAR, 16'sd12345);
    send_word(KIND_SAMPLE, 16'sd1000);
    send_word(KIND_CLEAR, -16'sd1);
    wait_idle();
  endtask

  task automatic test_register_limits();
    set_all(0, 24'hFFFFFF, 17'h1FFFF);
    write_reg(REG_UNUSED, 24'hA5A5A5);
    send_word(KIND_SAMPLE, 16'sd32767);
    send_word(KIND_SAMPLE, -16'sd32768);
    wait_idle();
  endtask

  task automatic test_factor_lowered_mid_group();
    set_all(4, 65536, 64880);
    send_word(KIND_SAMPLE, 16'sd20000);
    send_word(KIND_SAMPLE, 16'sd20000);
    wait_idle();
    write_reg(REG_DECIMATION, 24'd1);
    send_word(KIND_SAMPLE, -16'sd7000);
    wait_idle();
  endtask

  task automatic test_random_traffic();
    int f;
    int g;
    int p;
    int n;
    int offset;
    for (int phase = 0; phase < 12; phase++) begin
      case (phase)
        0: begin f = 1;  g = 65536;    p = 64880;  end
        1: begin f = 16; g = 24'hFFFFFF; p = 65536; end
        2: begin f = 31; g = 0;        p = 0;      end
        3: begin f = 0;  g = 24'hFFFFFF; p = 131071; end
        default: begin
          f = ($urandom_range(3) == 0) ? $urandom_range(31) : $urandom_range(1, 4);
          g = ($urandom_range(1) == 0) ? $urandom_range(24'hFFFFFF) : $urandom_range(32768, 262144);
          p = ($urandom_range(3) == 0) ? $urandom_range(131071) : $urandom_range(60000, 65536);
        end
      endcase
      set_all(f, g, p);
      steady = (phase == 3);
      n = (phase == 3) ? 150 : 72;
      offset = $signed(16'($urandom)) / 2;
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(99) < 4) send_word(KIND_CLEAR, 16'($urandom));
        else send_word(KIND_SAMPLE, pick_sample(offset));
      end
      wait_idle();
      steady = 1'b0;
    end
  endtask

  initial begin
    model_factor = FACTOR_RESET;
    model_gain = GAIN_RESET;
    model_pole = COEF_RESET;
    group_acc = 0;
    group_len = 0;
    last_scaled = 0;
    last_filtered = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_reset_defaults();
    test_clear_word();
    test_register_limits();
    test_factor_lowered_mid_group();
    test_random_traffic();
    $display("Sent %0d words over %0d register writes; checked %0d filtered results.",
             words_sent, reg_writes, results_checked);
    $display("Mismatches and stray results counted: %0d.", errors);
    if (errors == 0) begin
      $display("decimating_dc_block_highpass_unit_tb: done, clean");
    end else begin
      $display("decimating_dc_block_highpass_unit_tb: done, errors");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("Timed out with %0d results still outstanding.", expected_out.size());
    $display("decimating_dc_block_highpass_unit_tb: done, errors");
    $finish;
  end

endmodule
